### hdl/tuning_frame_receiver_unit_defines.svh
// Assertion macros shared by the tuning frame receiver files
`ifndef TUNING_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define TUNING_FRAME_RECEIVER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define TFR_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define TFR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### hdl/tfr_pkg.sv
// Shared types, constants and helpers of the tuning frame receiver
package tfr_pkg;

    localparam logic [7:0] SYNC0    = 8'hFF;
    localparam logic [7:0] SYNC1    = 8'h55;
    localparam logic [7:0] SYNC2    = 8'hAA;
    localparam logic [7:0] TAG_DATA = 8'h10;
    localparam logic [7:0] TAG_CMD  = 8'h77;

    localparam int unsigned HDR_LEN    = 4;
    localparam logic [2:0]  WORD_BYTES = 3'd4;
    localparam logic [31:0] VALUE_MAX  = 32'h7FFF_FFFF;

    typedef enum logic {
        KIND_VALUE = 1'b0,
        KIND_CMD   = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [3:0]         channel;
        logic signed [31:0] value;
        logic               last;
    } t_result;

    typedef struct packed {
        logic    load;
        t_result res;
    } t_out_ctl;

    // expected header byte at position pos for a frame with the given tag
    function automatic logic [7:0] hdr_byte(input logic [1:0] pos, input logic [7:0] tag);
        logic [7:0] b;
        case (pos)
            2'd0:    b = SYNC0;
            2'd1:    b = SYNC1;
            2'd2:    b = SYNC2;
            default: b = tag;
        endcase
        return b;
    endfunction

    // words above the signed maximum encode negatives as VALUE_MAX - w, wrapped
    function automatic logic signed [31:0] decode_word(input logic [31:0] w);
        logic [31:0] v;
        v = w[31] ? (VALUE_MAX - w) : w;
        return $signed(v);
    endfunction

endpackage

### hdl/tfr_if.sv
// Stream interfaces of the tuning frame receiver: received bytes and results
interface tfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tfr_result_if;
    import tfr_pkg::*;

    logic               valid;
    logic               ready;
    t_kind              kind;
    logic [3:0]         channel;
    logic signed [31:0] value;
    logic               last;

    modport source (output valid, output kind, output channel, output value, output last,
                    input ready);
    modport sink   (input valid, input kind, input channel, input value, input last,
                    output ready);
endinterface

### hdl/tfr_out_stage.sv
// Output register stage: holds one result until the downstream transfer
module tfr_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tfr_pkg::t_out_ctl i_ctl,
    output logic              o_free,
    tfr_result_if.source      o_res
);
    import tfr_pkg::*;

    logic    r_valid;
    t_result r_res;

    // slot is free when empty or when the held result transfers this cycle
    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_res <= i_ctl.res;
        end
    end

    assign o_res.valid   = r_valid;
    assign o_res.kind    = r_res.kind;
    assign o_res.channel = r_res.channel;
    assign o_res.value   = r_res.value;
    assign o_res.last    = r_res.last;

endmodule

### hdl/tuning_frame_receiver_unit.sv
// Tuning frame receiver top level: byte store, frame sequencer, result output
//
// i_rx carries one received byte per transfer; o_res carries results, each a
// channel value of a data frame (kind 0, channels 0..CHANNELS-1, last on the
// final channel) or the command byte of a command frame (kind 1, last set).
// Each byte that finds room is written into a single-port-write byte store at
// the fill count; a byte that arrives at a full store is dropped. A sequencer
// then reads the store one address per cycle while it issues reads, through a
// registered read port, pipelined: it checks the data frame header and
// checksum, falling back to the command frame on a data header miss. A good
// data frame takes a checksum walk over the frame, then for each channel the
// reads of its word bytes and a load into the output register. i_rx.ready is
// high only while the sequencer is idle; one result may wait in the output
// register while the next byte is taken. A stalled receiver holds the
// sequencer at the next result until the output register frees. Reset clears
// the fill count and the sequencer; the store contents stay undefined and need
// no clearing pass.
module tuning_frame_receiver_unit #(
    parameter int unsigned STORE_DEPTH    = 64,
    parameter int unsigned DATA_FRAME_LEN = 41,
    parameter int unsigned CMD_FRAME_LEN  = 7,
    parameter int unsigned CHANNELS       = 9
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tfr_byte_if.sink     i_rx,
    tfr_result_if.source o_res
);
    import tfr_pkg::*;

    `include "tuning_frame_receiver_unit_defines.svh"

    localparam int unsigned AW = $clog2(STORE_DEPTH);
    localparam int unsigned FW = $clog2(STORE_DEPTH + 1);
    localparam int unsigned OW = $clog2(DATA_FRAME_LEN);

    localparam logic [FW-1:0] DEPTH_F       = FW'(STORE_DEPTH);
    localparam logic [FW-1:0] DATA_LEN_F    = FW'(DATA_FRAME_LEN);
    localparam logic [FW-1:0] CMD_LEN_F     = FW'(CMD_FRAME_LEN);
    localparam logic [OW-1:0] DATA_LAST_OFF = OW'(DATA_FRAME_LEN - 2);
    localparam logic [OW-1:0] CMD_LAST_OFF  = OW'(CMD_FRAME_LEN - 2);
    localparam logic [OW-1:0] HDR_OFF       = OW'(HDR_LEN);
    localparam logic [3:0]    LAST_CH       = 4'(CHANNELS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WORD,
        ST_WORD_OUT,
        ST_CMD_OUT
    } t_state;

    // control state
    t_state        r_state, n_state;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_ret_vld, n_ret_vld;

    // sequencer payload
    logic [AW-1:0] r_base, n_base;
    logic [OW-1:0] r_iss, n_iss;
    logic [OW-1:0] r_ret_off, n_ret_off;
    logic          r_is_cmd, n_is_cmd;
    logic [7:0]    r_sum, n_sum;
    logic [7:0]    r_newest, n_newest;
    logic [31:0]   r_word, n_word;
    logic [2:0]    r_wcnt, n_wcnt;
    logic [3:0]    r_ch, n_ch;

    // byte store
    logic [7:0]    mem_store [STORE_DEPTH];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    logic          out_free;
    t_out_ctl      out_ctl;

    logic [FW-1:0] fill_inc;
    logic [OW-1:0] last_off;
    logic [7:0]    tag;
    logic [7:0]    sum_next;

    assign i_rx.ready = (r_state == ST_IDLE);
    assign fill_inc   = r_fill + FW'(1);
    assign last_off   = r_is_cmd ? CMD_LAST_OFF : DATA_LAST_OFF;
    assign tag        = r_is_cmd ? TAG_CMD : TAG_DATA;
    assign sum_next   = r_sum + r_rd_data;
    assign rd_addr    = r_base + AW'(r_iss);

    // reads only touch addresses below the newest byte, so no write forwarding
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_store[r_fill[AW-1:0]] <= i_rx.rx_byte;
        end
        r_rd_data <= mem_store[rd_addr];
    end

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_ret_vld = r_ret_vld;
        n_base    = r_base;
        n_iss     = r_iss;
        n_ret_off = r_ret_off;
        n_is_cmd  = r_is_cmd;
        n_sum     = r_sum;
        n_newest  = r_newest;
        n_word    = r_word;
        n_wcnt    = r_wcnt;
        n_ch      = r_ch;
        mem_we    = 1'b0;
        out_ctl   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_rx.valid) begin
                    if (r_fill >= DEPTH_F) begin
                        // drop the byte and restart the store
                        n_fill = '0;
                    end else begin
                        mem_we    = 1'b1;
                        n_fill    = fill_inc;
                        n_newest  = i_rx.rx_byte;
                        n_iss     = '0;
                        n_ret_vld = 1'b0;
                        n_sum     = '0;
                        if (fill_inc >= DATA_LEN_F) begin
                            n_state  = ST_SCAN;
                            n_is_cmd = 1'b0;
                            n_base   = AW'(fill_inc - DATA_LEN_F);
                        end else if (fill_inc >= CMD_LEN_F) begin
                            n_state  = ST_SCAN;
                            n_is_cmd = 1'b1;
                            n_base   = AW'(fill_inc - CMD_LEN_F);
                        end
                    end
                end
            end

            ST_SCAN: begin
                // issue the next read, one frame byte per cycle
                n_ret_vld = 1'b0;
                if (r_iss <= last_off) begin
                    n_iss     = r_iss + OW'(1);
                    n_ret_vld = 1'b1;
                    n_ret_off = r_iss;
                end
                if (r_ret_vld) begin
                    if (r_ret_off < HDR_OFF &&
                        r_rd_data != hdr_byte(r_ret_off[1:0], tag)) begin
                        // header miss: fall back to the command frame check, or else go idle
                        n_ret_vld = 1'b0;
                        if (!r_is_cmd && r_fill >= CMD_LEN_F) begin
                            n_is_cmd = 1'b1;
                            n_base   = AW'(r_fill - CMD_LEN_F);
                            n_iss    = '0;
                            n_sum    = '0;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_sum = sum_next;
                        if (r_ret_off == last_off) begin
                            // header matched: the store restarts either way
                            n_fill    = '0;
                            n_ret_vld = 1'b0;
                            n_state   = ST_IDLE;
                            if (sum_next == r_newest) begin
                                if (r_is_cmd) begin
                                    n_word  = {24'd0, r_rd_data};
                                    n_state = ST_CMD_OUT;
                                end else begin
                                    n_iss   = HDR_OFF;
                                    n_wcnt  = '0;
                                    n_ch    = '0;
                                    n_state = ST_WORD;
                                end
                            end
                        end
                    end
                end
            end

            ST_WORD: begin
                n_ret_vld = 1'b0;
                if (r_wcnt != WORD_BYTES) begin
                    n_iss     = r_iss + OW'(1);
                    n_wcnt    = r_wcnt + 3'd1;
                    n_ret_vld = 1'b1;
                    n_ret_off = r_iss;
                end
                if (r_ret_vld) begin
                    n_word = {r_word[23:0], r_rd_data};
                    // words are aligned, so the fourth byte ends in offset bits 11
                    if (r_ret_off[1:0] == 2'd3) begin
                        n_state = ST_WORD_OUT;
                    end
                end
            end

            ST_WORD_OUT: begin
                if (out_free) begin
                    out_ctl.load        = 1'b1;
                    out_ctl.res.kind    = KIND_VALUE;
                    out_ctl.res.channel = r_ch;
                    out_ctl.res.value   = decode_word(r_word);
                    out_ctl.res.last    = (r_ch == LAST_CH);
                    if (r_ch == LAST_CH) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_ch    = r_ch + 4'd1;
                        n_wcnt  = '0;
                        n_state = ST_WORD;
                    end
                end
            end

            ST_CMD_OUT: begin
                if (out_free) begin
                    out_ctl.load        = 1'b1;
                    out_ctl.res.kind    = KIND_CMD;
                    out_ctl.res.channel = 4'd0;
                    out_ctl.res.value   = $signed(r_word);
                    out_ctl.res.last    = 1'b1;
                    n_state             = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_ret_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_ret_vld <= n_ret_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base    <= n_base;
        r_iss     <= n_iss;
        r_ret_off <= n_ret_off;
        r_is_cmd  <= n_is_cmd;
        r_sum     <= n_sum;
        r_newest  <= n_newest;
        r_word    <= n_word;
        r_wcnt    <= n_wcnt;
        r_ch      <= n_ch;
    end

    tfr_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (out_ctl),
        .o_free  (out_free),
        .o_res   (o_res)
    );

    `TFR_ASSERT_NEXT(a_full_store_restarts, i_clk, i_rst_n,
        i_rx.valid && i_rx.ready && r_fill == DEPTH_F,
        r_fill == '0 && r_state == ST_IDLE, "full store did not restart")
    `TFR_ASSERT_IMPL(a_scan_ends_at_fill, i_clk, i_rst_n,
        r_state == ST_SCAN,
        FW'(r_base) + (r_is_cmd ? CMD_LEN_F : DATA_LEN_F) == r_fill,
        "scanned frame does not end at the newest byte")
    `TFR_ASSERT_IMPL(a_load_into_free_slot, i_clk, i_rst_n,
        out_ctl.load, out_free, "result loaded while output register busy")

endmodule

### test/tfr_frame_checker.sv
// Frame checker: predicts deframed results from accepted bytes and compares them
module tfr_frame_checker
    import tfr_pkg::*;
#(
    parameter int unsigned STORE_DEPTH    = 64,
    parameter int unsigned DATA_FRAME_LEN = 41,
    parameter int unsigned CMD_FRAME_LEN  = 7,
    parameter int unsigned CHANNELS       = 9
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tfr_byte_if   i_rx,
    tfr_result_if i_res,
    input  logic  i_end_check,
    output int    o_pending,
    output int    o_fail_cnt
);

    logic [7:0]  byte_mem [STORE_DEPTH];
    int unsigned fill_cnt = 0;
    t_result     pending_results [$];

    int fail_cnt     = 0;
    int bytes_in     = 0;
    int checked_cnt  = 0;
    int data_ok_cnt  = 0;
    int cmd_ok_cnt   = 0;
    int reject_cnt   = 0;
    int drop_cnt     = 0;
    bit end_reported = 1'b0;

    assign o_fail_cnt = fail_cnt;

    function automatic bit header_ends_here(input int unsigned len, input logic [7:0] tag);
        int unsigned s;
        if (fill_cnt < len)
            return 1'b0;
        s = fill_cnt - len;
        return byte_mem[s] == SYNC0 && byte_mem[s + 1] == SYNC1 &&
               byte_mem[s + 2] == SYNC2 && byte_mem[s + 3] == tag;
    endfunction

    function automatic bit checksum_good(input int unsigned len);
        logic [7:0] acc;
        acc = 8'd0;
        for (int unsigned i = fill_cnt - len; i + 1 < fill_cnt; i++)
            acc = acc + byte_mem[i];
        return acc == byte_mem[fill_cnt - 1];
    endfunction

    // append one byte and queue every result that it completes
    task automatic deframe_byte(input logic [7:0] b);
        int unsigned base;
        logic [31:0] word;
        t_result     r;
        bytes_in++;
        if (fill_cnt >= STORE_DEPTH) begin
            fill_cnt = 0;
            drop_cnt++;
            return;
        end
        byte_mem[fill_cnt] = b;
        fill_cnt++;
        if (header_ends_here(DATA_FRAME_LEN, TAG_DATA)) begin
            if (checksum_good(DATA_FRAME_LEN)) begin
                base = fill_cnt - DATA_FRAME_LEN + HDR_LEN;
                for (int unsigned ch = 0; ch < CHANNELS; ch++) begin
                    word = {byte_mem[base + 4 * ch], byte_mem[base + 4 * ch + 1],
                            byte_mem[base + 4 * ch + 2], byte_mem[base + 4 * ch + 3]};
                    // negative values travel as VALUE_MAX minus the word
                    if (word[31])
                        word = VALUE_MAX - word;
                    r.kind    = KIND_VALUE;
                    r.channel = 4'(ch);
                    r.value   = $signed(word);
                    r.last    = (ch + 1 == CHANNELS);
                    pending_results.push_back(r);
                end
                data_ok_cnt++;
            end else begin
                reject_cnt++;
            end
            fill_cnt = 0;
        end else if (header_ends_here(CMD_FRAME_LEN, TAG_CMD)) begin
            if (checksum_good(CMD_FRAME_LEN)) begin
                r.kind    = KIND_CMD;
                r.channel = 4'd0;
                r.value   = {24'd0, byte_mem[fill_cnt - 2]};
                r.last    = 1'b1;
                pending_results.push_back(r);
                cmd_ok_cnt++;
            end else begin
                reject_cnt++;
            end
            fill_cnt = 0;
        end
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        got.kind    = i_res.kind;
        got.channel = i_res.channel;
        got.value   = i_res.value;
        got.last    = i_res.last;
        checked_cnt++;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result kind %0d channel %0d value 0x%08h last %0d",
                     $time, got.kind, got.channel, got.value, got.last);
            fail_cnt++;
            return;
        end
        want = pending_results.pop_front();
        if (got !== want) begin
            $display("%0t: mismatch: expected kind %0d channel %0d value 0x%08h last %0d, got kind %0d channel %0d value 0x%08h last %0d",
                     $time, want.kind, want.channel, want.value, want.last,
                     got.kind, got.channel, got.value, got.last);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // compare before predicting so a stray result cannot match this byte's output
            if (i_res.valid && i_res.ready)
                check_result();
            if (i_rx.valid && i_rx.ready)
                deframe_byte(i_rx.rx_byte);
            if (i_end_check && !end_reported) begin
                end_reported = 1'b1;
                if (pending_results.size() != 0) begin
                    $display("%0t: %0d expected results never arrived, oldest value 0x%08h",
                             $time, pending_results.size(), pending_results[0].value);
                    fail_cnt += pending_results.size();
                end
                $display("Covered: %0d bytes in, %0d results checked", bytes_in, checked_cnt);
                $display("Frames: %0d data ok, %0d command ok, %0d bad checksum, %0d full-store drops",
                         data_ok_cnt, cmd_ok_cnt, reject_cnt, drop_cnt);
            end
        end
        o_pending <= pending_results.size();
    end

endmodule

### test/tb_top.sv
// Testbench top: byte and frame stimulus, result back-pressure, verdict
module tb_top;
    import tfr_pkg::*;

    localparam int unsigned STORE_DEPTH     = 64;
    localparam int unsigned DATA_FRAME_LEN  = 41;
    localparam int unsigned CMD_FRAME_LEN   = 7;
    localparam int unsigned CHANNELS        = 9;
    localparam int unsigned WORDS_PER_FRAME = (DATA_FRAME_LEN - HDR_LEN - 1) / 4;
    localparam int          RANDOM_BYTES    = 180;
    localparam int          QUIET_LIMIT     = 2000;
    localparam int          DRAIN_CYCLES    = 200;

    logic i_clk;
    logic i_rst_n;
    logic end_check;
    logic sink_ready = 1'b0;
    bit   sink_calm  = 1'b0;
    int   stall_left = 0;
    bit   src_calm   = 1'b0;
    int   bytes_sent = 0;
    int   quiet_cycles = 0;
    int   pending;
    int   fail_cnt;

    logic [7:0] frame_bytes [$];

    tfr_byte_if   rx_if ();
    tfr_result_if res_if ();

    assign res_if.ready = sink_ready;

    tuning_frame_receiver_unit #(
        .STORE_DEPTH   (STORE_DEPTH),
        .DATA_FRAME_LEN(DATA_FRAME_LEN),
        .CMD_FRAME_LEN (CMD_FRAME_LEN),
        .CHANNELS      (CHANNELS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rx   (rx_if),
        .o_res  (res_if)
    );

    tfr_frame_checker #(
        .STORE_DEPTH   (STORE_DEPTH),
        .DATA_FRAME_LEN(DATA_FRAME_LEN),
        .CMD_FRAME_LEN (CMD_FRAME_LEN),
        .CHANNELS      (CHANNELS)
    ) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx_if),
        .i_res      (res_if),
        .i_end_check(end_check),
        .o_pending  (pending),
        .o_fail_cnt (fail_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] edge_word(input int i);
        case (i)
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h0000_0001;
            5:       return 32'h8000_0001;
            6:       return 32'h0001_0000;
            7:       return 32'hFFFF_0000;
            default: return 32'h7FFF_FFFE;
        endcase
    endfunction

    // result side back-pressure, with calm stretches of steady ready
    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0)
            sink_calm <= ~sink_calm;
        if (sink_calm) begin
            sink_ready <= 1'b1;
        end else if (stall_left > 0) begin
            sink_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            sink_ready <= 1'b0;
            stall_left <= idle_len();
        end else begin
            sink_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // hold the byte until it is taken; keep valid high across back-to-back transfers
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = src_calm ? 0 : idle_len();
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        bytes_sent++;
    endtask

    task automatic send_queued();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i]);
        frame_bytes.delete();
    endtask

    task automatic send_frame(input bit corrupt);
        logic [7:0] sum;
        sum = 8'd0;
        foreach (frame_bytes[i])
            sum = sum + frame_bytes[i];
        if (corrupt)
            sum = sum + 8'($urandom_range(1, 255));
        frame_bytes.push_back(sum);
        send_queued();
    endtask

    task automatic queue_header(input logic [7:0] tag);
        frame_bytes.push_back(SYNC0);
        frame_bytes.push_back(SYNC1);
        frame_bytes.push_back(SYNC2);
        frame_bytes.push_back(tag);
    endtask

    task automatic queue_word(input logic [31:0] w);
        frame_bytes.push_back(w[31:24]);
        frame_bytes.push_back(w[23:16]);
        frame_bytes.push_back(w[15:8]);
        frame_bytes.push_back(w[7:0]);
    endtask

    task automatic queue_data_frame();
        queue_header(TAG_DATA);
        repeat (WORDS_PER_FRAME) queue_word(rand_word());
    endtask

    task automatic queue_cmd_frame(input logic [7:0] cmd);
        queue_header(TAG_CMD);
        repeat (CMD_FRAME_LEN - HDR_LEN - 2) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(cmd);
    endtask

    task automatic queue_junk(input int n, input bit no_sync);
        repeat (n)
            frame_bytes.push_back(no_sync ? 8'($urandom_range(0, 254)) : 8'($urandom));
    endtask

    initial begin
        int random_start;
        int pick;
        i_rst_n       <= 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'd0;
        end_check     <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // data frame carrying the word extremes
        queue_header(TAG_DATA);
        for (int i = 0; i < WORDS_PER_FRAME; i++)
            queue_word(edge_word(i));
        send_frame(1'b0);
        // command byte extremes
        queue_cmd_frame(8'h00);
        send_frame(1'b0);
        queue_cmd_frame(8'hFF);
        send_frame(1'b0);
        // bad checksums still clear the fill count
        queue_cmd_frame(8'($urandom));
        send_frame(1'b1);
        queue_data_frame();
        send_frame(1'b1);
        // command frame behind leading noise
        queue_junk(3, 1'b1);
        queue_cmd_frame(8'($urandom));
        send_frame(1'b0);
        // data frame whose tail is also a good command frame: data wins
        queue_header(TAG_DATA);
        repeat (29) frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'hF2);
        queue_header(TAG_CMD);
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'($urandom));
        send_frame(1'b0);
        // fill the store, drop one byte, then recover
        queue_junk(STORE_DEPTH, 1'b1);
        frame_bytes.push_back(SYNC0);
        send_queued();
        queue_cmd_frame(8'($urandom));
        send_frame(1'b0);

        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            src_calm = ($urandom_range(0, 3) == 0);
            pick     = $urandom_range(0, 99);
            if (pick < 30) begin
                queue_data_frame();
                send_frame(1'b0);
            end else if (pick < 62) begin
                queue_cmd_frame(8'($urandom));
                send_frame(1'b0);
            end else if (pick < 70) begin
                queue_data_frame();
                send_frame(1'b1);
            end else if (pick < 77) begin
                queue_cmd_frame(8'($urandom));
                send_frame(1'b1);
            end else if (pick < 88) begin
                queue_junk($urandom_range(1, 6), 1'b0);
                send_queued();
            end else if (pick < 95) begin
                // truncated frame: header and part of the body, no checksum
                queue_header($urandom_range(0, 1) ? TAG_DATA : TAG_CMD);
                queue_junk($urandom_range(0, 20), 1'b0);
                send_queued();
            end else if (pick < 98) begin
                frame_bytes.push_back(SYNC0);
                frame_bytes.push_back(SYNC1);
                queue_junk($urandom_range(1, 8), 1'b0);
                send_queued();
            end else begin
                queue_junk($urandom_range(60, 70), 1'b0);
                send_queued();
            end
        end
        rx_if.valid <= 1'b0;
        @(posedge i_clk);

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        end_check <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
